>>> sv/dsc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the drill sequence controller.
// No dependencies; the pattern store, sequencer and top-level files import this package.
package dsc_pkg;

  localparam int unsigned PATTERN_DEPTH = 64;
  localparam int unsigned ADDR_W = $clog2(PATTERN_DEPTH);
  localparam int unsigned PTR_W = $clog2(PATTERN_DEPTH + 1);

  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] END_MARK = 8'hFF;

  // control bit positions
  localparam int unsigned CTRL_PULSE = 0;
  localparam int unsigned CTRL_DIR = 1;
  localparam int unsigned CTRL_MOTOR = 2;
  localparam int unsigned CTRL_LOWER = 3;
  localparam int unsigned CTRL_ALARM = 4;
  localparam int unsigned CTRL_W = 5;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_START  = 2'd3
  } dsc_op_e;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_DONE    = 2'd1,
    OUT_BLOCKED = 2'd2,
    OUT_TIMEOUT = 2'd3
  } dsc_outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_TICKS   = 3'd0,
    CFG_SPINUP_TICKS  = 3'd1,
    CFG_BEEP_ON_TICKS = 3'd2,
    CFG_BEEP_GAP      = 3'd3,
    CFG_MOVE_TIMEOUT  = 3'd4
  } dsc_cfg_idx_e;

  typedef struct packed {
    logic [3:0] pulse_ticks;
    logic [3:0] spinup_ticks;
    logic [3:0] beep_on_ticks;
    logic [3:0] beep_gap_ticks;
    logic [4:0] move_timeout_ticks;
  } dsc_cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] step_count;
    logic       at_reference;
    logic       drill_raised;
    logic       drill_lowered;
  } dsc_req_t;

  typedef struct packed {
    logic [CTRL_W-1:0] ctrl;
    logic              busy;
    dsc_outcome_e      outcome;
  } dsc_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } dsc_ram_req_t;

endpackage

>>> sv/dsc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result items.
// Plain field widths; no package needed.
interface dsc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] step_count;
  logic       at_reference;
  logic       drill_raised;
  logic       drill_lowered;

  modport source (output valid, operation, step_count, at_reference, drill_raised,
                  drill_lowered, input ready);
  modport sink (input valid, operation, step_count, at_reference, drill_raised,
                drill_lowered, output ready);
endinterface

interface dsc_rsp_if;
  logic       valid;
  logic       ready;
  logic       step_pulse;
  logic       step_direction;
  logic       motor_on;
  logic       lower_drill;
  logic       alarm_sound;
  logic       busy_res;
  logic [1:0] outcome;

  modport source (output valid, step_pulse, step_direction, motor_on, lower_drill,
                  alarm_sound, busy_res, outcome, input ready);
  modport sink (input valid, step_pulse, step_direction, motor_on, lower_drill,
                alarm_sound, busy_res, outcome, output ready);
endinterface

>>> sv/dsc_pattern_ram.sv
`timescale 1ns / 1ps
// Hole pattern store: one write port, one registered read port.
// Depends on dsc_pkg.
module dsc_pattern_ram
  import dsc_pkg::*;
(
  input  logic         clk_i,
  input  dsc_ram_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem [PATTERN_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // forward a same-cycle write so the read sees the new entry
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rdata_q <= req_i.wdata;
    end else begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dsc_sequencer.sv
`timescale 1ns / 1ps
// Drill run state machine: at most one state transition per request.
// Depends on dsc_pkg; drives the pattern store port.
module dsc_sequencer
  import dsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  dsc_req_t     req_i,
  input  dsc_cfg_t     cfg_i,
  input  logic [7:0]   entry_i,
  output dsc_ram_req_t ram_o,
  output dsc_res_t     res_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_REF,
    PH_REF_PULSE,
    PH_SPINUP,
    PH_NSTEP,
    PH_NPULSE,
    PH_DOWN,
    PH_UP,
    PH_BEEP_STEP_ON,
    PH_BEEP_STEP_GAP,
    PH_BEEP_MOVE_ON,
    PH_BEEP_MOVE_GAP
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CTRL_W-1:0] ctrl_q, ctrl_d;
  logic [4:0]        wait_q, wait_d;
  logic [7:0]        steps_q, steps_d;
  logic [1:0]        beeps_q, beeps_d;
  logic [PTR_W-1:0]  load_q, load_d;
  logic [PTR_W-1:0]  run_q, run_d;
  dsc_outcome_e      outcome_d;

  logic              busy;
  logic              cnt_done;
  logic [4:0]        wait_dec;
  logic [PTR_W-1:0]  fetch_ptr;
  logic              fetch_end;
  logic [PTR_W-1:0]  raddr_ptr;
  logic [1:0]        beeps_dec;
  dsc_op_e           op;

  assign op        = dsc_op_e'(req_i.operation);
  assign busy      = (phase_q != PH_IDLE);
  assign cnt_done  = (wait_q <= 5'd1);
  assign wait_dec  = cnt_done ? 5'd0 : wait_q - 5'd1;
  assign beeps_dec = beeps_q - 2'd1;
  // the entry held in the read register belongs to this pointer
  assign fetch_ptr = (phase_q == PH_UP) ? run_q + PTR_W'(1) : run_q;
  assign fetch_end = (fetch_ptr >= load_q) || (fetch_ptr >= PTR_W'(PATTERN_DEPTH))
                     || (entry_i == END_MARK);

  always_comb begin
    phase_d   = phase_q;
    ctrl_d    = ctrl_q;
    wait_d    = wait_q;
    steps_d   = steps_q;
    beeps_d   = beeps_q;
    load_d    = load_q;
    run_d     = run_q;
    outcome_d = OUT_NONE;
    ram_o.we    = 1'b0;
    ram_o.waddr = load_q[ADDR_W-1:0];
    ram_o.wdata = req_i.step_count;

    if (step_i) begin
      if (busy) begin
        if (op == OP_TICK) begin
          case (phase_q)
            PH_REF: begin
              if (req_i.at_reference) begin
                if (ctrl_q[CTRL_MOTOR]) begin
                  if (fetch_end) begin
                    ctrl_d    = ctrl_q & (CTRL_W'(1) << CTRL_LOWER);
                    phase_d   = PH_IDLE;
                    outcome_d = OUT_DONE;
                  end else begin
                    steps_d          = entry_i;
                    ctrl_d[CTRL_DIR] = 1'b1;
                    phase_d          = PH_NSTEP;
                  end
                end else begin
                  ctrl_d[CTRL_MOTOR] = 1'b1;
                  wait_d             = {1'b0, cfg_i.spinup_ticks};
                  phase_d            = PH_SPINUP;
                end
              end else if (!req_i.drill_raised) begin
                ctrl_d[CTRL_ALARM] = 1'b1;
                beeps_d            = 2'd3;
                wait_d             = {1'b0, cfg_i.beep_on_ticks};
                phase_d            = PH_BEEP_STEP_ON;
              end else begin
                ctrl_d[CTRL_DIR]   = 1'b1;
                ctrl_d[CTRL_PULSE] = 1'b1;
                wait_d             = {1'b0, cfg_i.pulse_ticks};
                phase_d            = PH_REF_PULSE;
              end
            end
            PH_REF_PULSE: begin
              wait_d = wait_dec;
              if (cnt_done) begin
                ctrl_d[CTRL_DIR]   = 1'b0;
                ctrl_d[CTRL_PULSE] = 1'b0;
                phase_d            = PH_REF;
              end
            end
            PH_SPINUP: begin
              wait_d = wait_dec;
              if (cnt_done) begin
                if (fetch_end) begin
                  ctrl_d    = ctrl_q & (CTRL_W'(1) << CTRL_LOWER);
                  phase_d   = PH_IDLE;
                  outcome_d = OUT_DONE;
                end else begin
                  steps_d          = entry_i;
                  ctrl_d[CTRL_DIR] = 1'b1;
                  phase_d          = PH_NSTEP;
                end
              end
            end
            PH_NSTEP: begin
              if (steps_q == 8'd0) begin
                ctrl_d[CTRL_DIR]   = 1'b0;
                ctrl_d[CTRL_LOWER] = 1'b1;
                wait_d             = cfg_i.move_timeout_ticks;
                phase_d            = PH_DOWN;
              end else if (!req_i.drill_raised) begin
                ctrl_d[CTRL_ALARM] = 1'b1;
                beeps_d            = 2'd3;
                wait_d             = {1'b0, cfg_i.beep_on_ticks};
                phase_d            = PH_BEEP_STEP_ON;
              end else begin
                ctrl_d[CTRL_PULSE] = 1'b1;
                wait_d             = {1'b0, cfg_i.pulse_ticks};
                phase_d            = PH_NPULSE;
              end
            end
            PH_NPULSE: begin
              wait_d = wait_dec;
              if (cnt_done) begin
                ctrl_d[CTRL_PULSE] = 1'b0;
                steps_d            = steps_q - 8'd1;
                phase_d            = PH_NSTEP;
              end
            end
            PH_DOWN: begin
              if (req_i.drill_lowered) begin
                ctrl_d[CTRL_LOWER] = 1'b0;
                wait_d             = cfg_i.move_timeout_ticks;
                phase_d            = PH_UP;
              end else if (wait_q == 5'd0) begin
                ctrl_d[CTRL_ALARM] = 1'b1;
                beeps_d            = 2'd2;
                wait_d             = {1'b0, cfg_i.beep_on_ticks};
                phase_d            = PH_BEEP_MOVE_ON;
              end else begin
                wait_d = wait_q - 5'd1;
              end
            end
            PH_UP: begin
              if (req_i.drill_raised) begin
                run_d = fetch_ptr;
                if (fetch_end) begin
                  ctrl_d    = ctrl_q & (CTRL_W'(1) << CTRL_LOWER);
                  phase_d   = PH_IDLE;
                  outcome_d = OUT_DONE;
                end else begin
                  steps_d          = entry_i;
                  ctrl_d[CTRL_DIR] = 1'b1;
                  phase_d          = PH_NSTEP;
                end
              end else if (wait_q == 5'd0) begin
                ctrl_d[CTRL_ALARM] = 1'b1;
                beeps_d            = 2'd2;
                wait_d             = {1'b0, cfg_i.beep_on_ticks};
                phase_d            = PH_BEEP_MOVE_ON;
              end else begin
                wait_d = wait_q - 5'd1;
              end
            end
            PH_BEEP_STEP_ON, PH_BEEP_MOVE_ON: begin
              wait_d = wait_dec;
              if (cnt_done) begin
                ctrl_d[CTRL_ALARM] = 1'b0;
                beeps_d            = beeps_dec;
                if (beeps_dec == 2'd0) begin
                  ctrl_d    = ctrl_q & (CTRL_W'(1) << CTRL_LOWER);
                  phase_d   = PH_IDLE;
                  outcome_d = (phase_q == PH_BEEP_STEP_ON) ? OUT_BLOCKED : OUT_TIMEOUT;
                end else begin
                  wait_d  = {1'b0, cfg_i.beep_gap_ticks};
                  phase_d = (phase_q == PH_BEEP_STEP_ON) ? PH_BEEP_STEP_GAP
                                                         : PH_BEEP_MOVE_GAP;
                end
              end
            end
            PH_BEEP_STEP_GAP, PH_BEEP_MOVE_GAP: begin
              wait_d = wait_dec;
              if (cnt_done) begin
                ctrl_d[CTRL_ALARM] = 1'b1;
                wait_d             = {1'b0, cfg_i.beep_on_ticks};
                phase_d = (phase_q == PH_BEEP_STEP_GAP) ? PH_BEEP_STEP_ON
                                                        : PH_BEEP_MOVE_ON;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end else begin
        case (op)
          OP_APPEND: begin
            if (load_q < PTR_W'(PATTERN_DEPTH)) begin
              ram_o.we = 1'b1;
              load_d   = load_q + PTR_W'(1);
            end
          end
          OP_CLEAR: begin
            load_d = '0;
          end
          OP_START: begin
            run_d   = '0;
            steps_d = '0;
            beeps_d = '0;
            wait_d  = '0;
            phase_d = PH_REF;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    // prefetch the entry the next fetch will need
    raddr_ptr   = (phase_d == PH_UP) ? run_d + PTR_W'(1) : run_d;
    ram_o.raddr = raddr_ptr[ADDR_W-1:0];
  end

  assign res_o.ctrl    = ctrl_d;
  assign res_o.busy    = (phase_d != PH_IDLE);
  assign res_o.outcome = outcome_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ctrl_q  <= '0;
      wait_q  <= '0;
      steps_q <= '0;
      beeps_q <= '0;
      load_q  <= '0;
      run_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ctrl_q  <= ctrl_d;
      wait_q  <= wait_d;
      steps_q <= steps_d;
      beeps_q <= beeps_d;
      load_q  <= load_d;
      run_q   <= run_d;
    end
  end

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q <= PTR_W'(PATTERN_DEPTH))
    else $error("load pointer beyond store depth");

  a_alarm_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q[CTRL_ALARM] == ((phase_q == PH_BEEP_STEP_ON) || (phase_q == PH_BEEP_MOVE_ON)))
    else $error("alarm bit out of step with beep phase");

  a_pulse_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q[CTRL_PULSE] |-> ((phase_q == PH_REF_PULSE) || (phase_q == PH_NPULSE)))
    else $error("step pulse high outside a pulse phase");

endmodule

>>> sv/drill_sequence_controller.sv
`timescale 1ns / 1ps
// Drill sequence controller top level: an accepted request lands in the input
// register, and the result register loads from it once that register is free or
// being drained; the controller takes one request per cycle while the sink keeps
// ready high, set by the single-pass state update between the two registers.
// Reset (rst_ni, async, active low) idles the run, clears controls and pointers,
// and loads register defaults; the pattern store needs no clearing pass.
module drill_sequence_controller
  import dsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dsc_req_if.sink               req_i,
  dsc_rsp_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  dsc_cfg_t     cfg_q;

  // input register
  logic         in_valid_q;
  dsc_req_t     in_q;

  // result register
  logic         out_valid_q;
  dsc_res_t     out_q;

  logic         advance;
  dsc_res_t     res;
  dsc_ram_req_t ram_req;
  logic [7:0]   entry;

  // Move the held request on when the result register is free or being drained.
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ticks        <= 4'd2;
      cfg_q.spinup_ticks       <= 4'd4;
      cfg_q.beep_on_ticks      <= 4'd4;
      cfg_q.beep_gap_ticks     <= 4'd2;
      cfg_q.move_timeout_ticks <= 5'd20;
    end else if (cfg_we_i) begin
      // drop writes to indexes beyond the register list
      case (dsc_cfg_idx_e'(cfg_index_i))
        CFG_PULSE_TICKS:   cfg_q.pulse_ticks        <= cfg_data_i[3:0];
        CFG_SPINUP_TICKS:  cfg_q.spinup_ticks       <= cfg_data_i[3:0];
        CFG_BEEP_ON_TICKS: cfg_q.beep_on_ticks      <= cfg_data_i[3:0];
        CFG_BEEP_GAP:      cfg_q.beep_gap_ticks     <= cfg_data_i[3:0];
        CFG_MOVE_TIMEOUT:  cfg_q.move_timeout_ticks <= cfg_data_i;
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  // Hold the accepted request until the sequencer consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q.operation     <= req_i.operation;
      in_q.step_count    <= req_i.step_count;
      in_q.at_reference  <= req_i.at_reference;
      in_q.drill_raised  <= req_i.drill_raised;
      in_q.drill_lowered <= req_i.drill_lowered;
    end
  end

  dsc_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .req_i   (in_q),
    .cfg_i   (cfg_q),
    .entry_i (entry),
    .ram_o   (ram_req),
    .res_o   (res)
  );

  dsc_pattern_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (entry)
  );

  // Result register: load on advance, clear valid once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.step_pulse     = out_q.ctrl[CTRL_PULSE];
  assign rsp_o.step_direction = out_q.ctrl[CTRL_DIR];
  assign rsp_o.motor_on       = out_q.ctrl[CTRL_MOTOR];
  assign rsp_o.lower_drill    = out_q.ctrl[CTRL_LOWER];
  assign rsp_o.alarm_sound    = out_q.ctrl[CTRL_ALARM];
  assign rsp_o.busy_res       = out_q.busy;
  assign rsp_o.outcome        = out_q.outcome;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("consumed request produced no result");

  a_outcome_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.outcome != OUT_NONE)) |-> !out_q.busy)
    else $error("run outcome reported while still busy");

endmodule
